// File: rtl/core/assert_macros.svh
// Assertion helpers for the stereo ADPCM core.
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: whenever ante holds, cons holds too.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication: whenever ante holds, cons holds in the cycle after.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/sadpcm_pkg.sv
// ---------------------------------------------------------------------------
// sadpcm_pkg
// Shared widths, register codes, lane structs and step tables for the
// stereo ADPCM nibble decoder.
// ---------------------------------------------------------------------------
`default_nettype none

package sadpcm_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int INDEX_W    = 7;
	localparam int CODE_W     = 4;
	localparam int MAG_W      = 3;
	localparam int STEP_W     = 15;
	localparam int BYTE_W     = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int IDX_LAST   = 88;

	localparam logic [INDEX_W-1:0] IDX_MAX = INDEX_W'(IDX_LAST);
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_INIT_LEFT_SAMPLE  = 2'd0,
		REG_INIT_LEFT_INDEX   = 2'd1,
		REG_INIT_RIGHT_SAMPLE = 2'd2,
		REG_INIT_RIGHT_INDEX  = 2'd3
	} cfg_reg_t;

	// Per-lane control from the top level.
	typedef struct packed {
		logic advance;  // beat accepted this cycle
		logic load;     // reload channel state from the init registers first
	} lane_ctl_t;

	// Chunk start values for one lane.
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic [INDEX_W-1:0]         index;
	} lane_init_t;

	// What a lane produces for the current beat.
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic [INDEX_W-1:0]         index;
	} lane_res_t;

	localparam logic [STEP_W-1:0] STEP_TABLE [0:IDX_LAST] = '{
		15'd7,     15'd8,     15'd9,     15'd10,    15'd11,    15'd12,    15'd13,
		15'd14,    15'd16,    15'd17,    15'd19,    15'd21,    15'd23,    15'd25,
		15'd28,    15'd31,    15'd34,    15'd37,    15'd41,    15'd45,    15'd50,
		15'd55,    15'd60,    15'd66,    15'd73,    15'd80,    15'd88,    15'd97,
		15'd107,   15'd118,   15'd130,   15'd143,   15'd157,   15'd173,   15'd190,
		15'd209,   15'd230,   15'd253,   15'd279,   15'd307,   15'd337,   15'd371,
		15'd408,   15'd449,   15'd494,   15'd544,   15'd598,   15'd658,   15'd724,
		15'd796,   15'd876,   15'd963,   15'd1060,  15'd1166,  15'd1282,  15'd1411,
		15'd1552,  15'd1707,  15'd1878,  15'd2066,  15'd2272,  15'd2499,  15'd2749,
		15'd3024,  15'd3327,  15'd3660,  15'd4026,  15'd4428,  15'd4871,  15'd5358,
		15'd5894,  15'd6484,  15'd7132,  15'd7845,  15'd8630,  15'd9493,  15'd10442,
		15'd11487, 15'd12635, 15'd13899, 15'd15289, 15'd16818, 15'd18500, 15'd20350,
		15'd22385, 15'd24623, 15'd27086, 15'd29794, 15'd32767
	};

	function automatic logic [STEP_W-1:0] step_lookup(input logic [INDEX_W-1:0] idx);
		logic [STEP_W-1:0] step;
		if (idx <= IDX_MAX) begin
			step = STEP_TABLE[idx];
		end else begin
			step = STEP_TABLE[IDX_LAST];
		end
		return step;
	endfunction

	// Index adjustment, indexed by the code magnitude.
	function automatic logic signed [INDEX_W:0] index_move(input logic [MAG_W-1:0] mag);
		logic signed [INDEX_W:0] mv;
		case (mag)
			3'd4:    mv = 8'sd2;
			3'd5:    mv = 8'sd4;
			3'd6:    mv = 8'sd6;
			3'd7:    mv = 8'sd8;
			default: mv = -8'sd1;
		endcase
		return mv;
	endfunction

	function automatic logic [INDEX_W-1:0] clamp_index(input logic [INDEX_W-1:0] idx);
		return (idx > IDX_MAX) ? IDX_MAX : idx;
	endfunction

endpackage

`default_nettype wire

// File: rtl/core/sadpcm_if.sv
// ---------------------------------------------------------------------------
// sadpcm_if
// Valid/ready channels of the stereo ADPCM decoder: coded bytes in,
// sample pairs out.
// ---------------------------------------------------------------------------
`default_nettype none

interface sadpcm_byte_if import sadpcm_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] code_byte;
	logic              first_of_chunk;

	modport source (output valid, code_byte, first_of_chunk, input ready);
	modport sink   (input valid, code_byte, first_of_chunk, output ready);
endinterface

interface sadpcm_pcm_if import sadpcm_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] left_sample;
	logic signed [SAMPLE_W-1:0] right_sample;

	modport source (output valid, left_sample, right_sample, input ready);
	modport sink   (input valid, left_sample, right_sample, output ready);
endinterface

`default_nettype wire

// File: rtl/core/sadpcm_lane.sv
// ---------------------------------------------------------------------------
// sadpcm_lane
// One channel of the decoder: holds predictor and step index, decodes one
// 4-bit code per accepted beat.
// ---------------------------------------------------------------------------
`default_nettype none

module sadpcm_lane import sadpcm_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire lane_ctl_t         ctl,
	input  wire lane_init_t        init,
	input  wire logic [CODE_W-1:0] code,
	output lane_res_t              res
);

	logic signed [SAMPLE_W-1:0] pred_q;
	logic [INDEX_W-1:0]         idx_q;

	logic signed [SAMPLE_W-1:0] base_pred;
	logic [INDEX_W-1:0]         base_idx;
	logic [STEP_W-1:0]          step;
	logic [MAG_W-1:0]           mag;
	logic [MAG_W+STEP_W-1:0]    prod;
	logic [SAMPLE_W-1:0]        diff;
	logic signed [SAMPLE_W+1:0] sum;
	logic signed [INDEX_W:0]    idx_sum;

	assign base_pred = ctl.load ? init.sample : pred_q;
	assign base_idx  = ctl.load ? clamp_index(init.index) : idx_q;
	assign step      = step_lookup(base_idx);
	assign mag       = code[MAG_W-1:0];
	assign prod      = {{STEP_W{1'b0}}, mag} * {{MAG_W{1'b0}}, step};
	assign diff      = prod[MAG_W+STEP_W-1:2];

	always_comb begin
		if (code[CODE_W-1]) begin
			sum = {{2{base_pred[SAMPLE_W-1]}}, base_pred} - $signed({2'b00, diff});
		end else begin
			sum = {{2{base_pred[SAMPLE_W-1]}}, base_pred} + $signed({2'b00, diff});
		end

		if (sum > $signed({{2{1'b0}}, SAMPLE_MAX})) begin
			res.sample = SAMPLE_MAX;
		end else if (sum < $signed({{2{1'b1}}, SAMPLE_MIN})) begin
			res.sample = SAMPLE_MIN;
		end else begin
			res.sample = sum[SAMPLE_W-1:0];
		end

		idx_sum = $signed({1'b0, base_idx}) + index_move(mag);
		if (idx_sum < 0) begin
			res.index = '0;
		end else if (idx_sum > $signed({1'b0, IDX_MAX})) begin
			res.index = IDX_MAX;
		end else begin
			res.index = idx_sum[INDEX_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pred_q <= '0;
			idx_q  <= '0;
		end else if (ctl.advance) begin
			pred_q <= res.sample;
			idx_q  <= res.index;
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/sadpcm_merge.sv
// ---------------------------------------------------------------------------
// sadpcm_merge
// Joins the two lane samples into one output beat and holds it in the
// output register until the sink takes it.
// ---------------------------------------------------------------------------
`default_nettype none

module sadpcm_merge import sadpcm_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      advance,
	input  wire lane_res_t left_res,
	input  wire lane_res_t right_res,
	output logic           take_ok,
	sadpcm_pcm_if.source   pcm
);

	logic                       valid_q;
	logic signed [SAMPLE_W-1:0] left_q;
	logic signed [SAMPLE_W-1:0] right_q;

	// Room for a new beat when empty or when the held beat leaves now.
	assign take_ok = !valid_q || pcm.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take_ok) begin
			valid_q <= advance;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			left_q  <= left_res.sample;
			right_q <= right_res.sample;
		end
	end

	assign pcm.valid        = valid_q;
	assign pcm.left_sample  = left_q;
	assign pcm.right_sample = right_q;

endmodule

`default_nettype wire

// File: rtl/core/stereo_adpcm_nibble_decoder_core.sv
// ---------------------------------------------------------------------------
// stereo_adpcm_nibble_decoder_core
// Stereo 4-bit ADPCM decoder: one code byte in, one left/right sample pair
// out.
// ---------------------------------------------------------------------------
// Each beat on the coded channel carries one byte; the high nibble is a left
// code and the low nibble a right code. Two lanes decode the nibbles side by
// side, each keeping its own 16-bit predictor and 0..88 step index. The
// difference is ((code & 7) * step) >> 2 using the step of the index held
// before the beat; bit 3 of the code subtracts. The predictor saturates to
// the signed 16-bit range and the index moves by the usual IMA table and is
// clamped to 0..88. With first_of_chunk set, both lanes reload predictor and
// index from the init registers (an index above 88 loads as 88) before the
// byte is decoded. Throughput is one byte per clock while the sink keeps
// taking pairs: the only loop is each lane's state feedback (step table read,
// 3x15 multiply, add and saturate). The sample pair of an accepted byte is
// in the output register in the next cycle. The coded channel stays
// ready while the output register is empty or being drained, so bytes keep
// flowing under a continuously ready sink. The configuration port writes
// registers 0..3 (left sample, left index, right sample, right index); write
// it only while no decoded beat is pending.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module stereo_adpcm_nibble_decoder_core import sadpcm_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	sadpcm_byte_if.sink                coded,
	sadpcm_pcm_if.source               decoded
);

	// Chunk start registers.
	lane_init_t left_init_q;
	lane_init_t right_init_q;

	lane_ctl_t  lane_ctl;
	lane_res_t  left_res;
	lane_res_t  right_res;
	logic       take_ok;
	logic       beat_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_init_q  <= '0;
			right_init_q <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_INIT_LEFT_SAMPLE:  left_init_q.sample  <= cfg_data[SAMPLE_W-1:0];
				REG_INIT_LEFT_INDEX:   left_init_q.index   <= cfg_data[INDEX_W-1:0];
				REG_INIT_RIGHT_SAMPLE: right_init_q.sample <= cfg_data[SAMPLE_W-1:0];
				REG_INIT_RIGHT_INDEX:  right_init_q.index  <= cfg_data[INDEX_W-1:0];
				default: ;
			endcase
		end
	end

	// Accept a byte whenever the output register has room.
	assign coded.ready      = take_ok;
	assign beat_in          = coded.valid && take_ok;
	assign lane_ctl.advance = beat_in;
	assign lane_ctl.load    = coded.first_of_chunk;

	// Left lane decodes the high nibble, right lane the low nibble.
	sadpcm_lane u_left_lane (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (lane_ctl),
		.init   (left_init_q),
		.code   (coded.code_byte[BYTE_W-1:CODE_W]),
		.res    (left_res)
	);

	sadpcm_lane u_right_lane (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (lane_ctl),
		.init   (right_init_q),
		.code   (coded.code_byte[CODE_W-1:0]),
		.res    (right_res)
	);

	// Combine both lanes into the output beat.
	sadpcm_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (beat_in),
		.left_res  (left_res),
		.right_res (right_res),
		.take_ok   (take_ok),
		.pcm       (decoded)
	);

	`ASSERT_IMPL(a_ready_when_empty, !decoded.valid, coded.ready, "coded stalled with empty output")
	`ASSERT_NEXT(a_beat_fills_output, beat_in, decoded.valid, "accepted byte produced no output")
	`ASSERT_NEXT(a_left_sample_lands, beat_in, decoded.left_sample == $past(left_res.sample), "left sample lost")
	`ASSERT_IMPL(a_left_index_range, beat_in, left_res.index <= IDX_MAX, "left step index out of range")
	`ASSERT_IMPL(a_right_index_range, beat_in, right_res.index <= IDX_MAX, "right step index out of range")

endmodule

`default_nettype wire

// File: verif/sadpcm_tracker_pkg.sv
// ---------------------------------------------------------------------------
// sadpcm_tracker_pkg
// Sample pair tracker for the stereo ADPCM decoder bench: keeps its own copy
// of the init registers and channel state, decodes each accepted code byte
// and compares the sample pairs the block returns, oldest first.
// ---------------------------------------------------------------------------
package sadpcm_tracker_pkg;

	import sadpcm_pkg::*;

	// IMA step sizes, one per step index 0..88.
	localparam int unsigned IMA_STEP [0:88] = '{
		7, 8, 9, 10, 11, 12, 13, 14, 16, 17, 19, 21, 23, 25, 28, 31,
		34, 37, 41, 45, 50, 55, 60, 66, 73, 80, 88, 97, 107, 118, 130, 143,
		157, 173, 190, 209, 230, 253, 279, 307, 337, 371, 408, 449, 494, 544,
		598, 658, 724, 796, 876, 963, 1060, 1166, 1282, 1411, 1552, 1707,
		1878, 2066, 2272, 2499, 2749, 3024, 3327, 3660, 4026, 4428, 4871,
		5358, 5894, 6484, 7132, 7845, 8630, 9493, 10442, 11487, 12635, 13899,
		15289, 16818, 18500, 20350, 22385, 24623, 27086, 29794, 32767
	};

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] left;
		logic signed [SAMPLE_W-1:0] right;
	} sample_pair_t;

	class stereo_sample_tracker;
		logic [SAMPLE_W-1:0]        init_left_sample;
		logic [INDEX_W-1:0]         init_left_index;
		logic [SAMPLE_W-1:0]        init_right_sample;
		logic [INDEX_W-1:0]         init_right_index;
		logic signed [SAMPLE_W-1:0] left_pred;
		logic signed [SAMPLE_W-1:0] right_pred;
		logic [INDEX_W-1:0]         left_idx;
		logic [INDEX_W-1:0]         right_idx;
		sample_pair_t               pending_pairs [$];
		int                         mismatches;
		int                         pairs_checked;
		int                         bytes_decoded;
		int                         chunk_reloads;
		int                         saturations;

		function new();
			init_left_sample  = '0;
			init_left_index   = '0;
			init_right_sample = '0;
			init_right_index  = '0;
			left_pred         = '0;
			right_pred        = '0;
			left_idx          = '0;
			right_idx         = '0;
			mismatches        = 0;
			pairs_checked     = 0;
			bytes_decoded     = 0;
			chunk_reloads     = 0;
			saturations       = 0;
		endfunction

		function void write_reg(cfg_reg_t sel, logic [CFG_DATA_W-1:0] data);
			case (sel)
				REG_INIT_LEFT_SAMPLE:  init_left_sample  = data;
				REG_INIT_LEFT_INDEX:   init_left_index   = data[INDEX_W-1:0];
				REG_INIT_RIGHT_SAMPLE: init_right_sample = data;
				REG_INIT_RIGHT_INDEX:  init_right_index  = data[INDEX_W-1:0];
				default: ;
			endcase
		endfunction

		function logic [INDEX_W-1:0] chunk_index(logic [INDEX_W-1:0] raw);
			return (int'(raw) > IDX_LAST) ? INDEX_W'(IDX_LAST) : raw;
		endfunction

		// Advance one channel by one nibble; the step comes from the old index.
		function void step_lane(input logic [CODE_W-1:0] code,
				inout logic signed [SAMPLE_W-1:0] pred,
				inout logic [INDEX_W-1:0] idx);
			int step;
			int diff;
			int acc;
			int nxt;
			step = IMA_STEP[idx];
			diff = (int'(code[MAG_W-1:0]) * step) >>> 2;
			acc  = code[MAG_W] ? int'(pred) - diff : int'(pred) + diff;
			if (acc > 32767) begin
				acc = 32767;
				saturations++;
			end else if (acc < -32768) begin
				acc = -32768;
				saturations++;
			end
			pred = acc[SAMPLE_W-1:0];
			nxt  = int'(idx) + (code[2] ? 2 * (int'(code[1:0]) + 1) : -1);
			if (nxt < 0) nxt = 0;
			if (nxt > IDX_LAST) nxt = IDX_LAST;
			idx = nxt[INDEX_W-1:0];
		endfunction

		function void decode_byte(logic [BYTE_W-1:0] code_byte, logic first_of_chunk);
			sample_pair_t pair;
			if (first_of_chunk) begin
				left_pred  = init_left_sample;
				left_idx   = chunk_index(init_left_index);
				right_pred = init_right_sample;
				right_idx  = chunk_index(init_right_index);
				chunk_reloads++;
			end
			step_lane(code_byte[7:4], left_pred, left_idx);
			step_lane(code_byte[3:0], right_pred, right_idx);
			pair.left  = left_pred;
			pair.right = right_pred;
			pending_pairs.push_back(pair);
			bytes_decoded++;
		endfunction

		function int pending();
			return pending_pairs.size();
		endfunction

		task report_mismatch(string msg);
			$display("MISMATCH: %s", msg);
			mismatches++;
		endtask

		task compare_pair(logic signed [SAMPLE_W-1:0] left, logic signed [SAMPLE_W-1:0] right);
			sample_pair_t want;
			if (pending_pairs.size() == 0) begin
				report_mismatch($sformatf("sample pair L=%0d R=%0d with none expected",
					left, right));
			end else begin
				want = pending_pairs.pop_front();
				if (left !== want.left)
					report_mismatch($sformatf("pair %0d left_sample %0d, expected %0d",
						pairs_checked, left, want.left));
				if (right !== want.right)
					report_mismatch($sformatf("pair %0d right_sample %0d, expected %0d",
						pairs_checked, right, want.right));
				pairs_checked++;
			end
		endtask
	endclass

endpackage

// File: verif/stereo_adpcm_nibble_decoder_core_tb.sv
// ---------------------------------------------------------------------------
// stereo_adpcm_nibble_decoder_core_tb
// Drives code bytes into the stereo ADPCM decoder under bursty input and a
// stalling sink, predicts every left/right sample pair and checks each one.
// ---------------------------------------------------------------------------
module stereo_adpcm_nibble_decoder_core_tb;

	timeunit 1ns;
	timeprecision 1ps;

	import sadpcm_pkg::*;
	import sadpcm_tracker_pkg::*;

	localparam int RESET_CYCLES    = 10;
	localparam int DRAIN_CYCLES    = 4;     // settle margin after the last pair
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int WATCHDOG_LIMIT  = 5000;  // well above the long hold-off
	localparam int PHASES          = 7;
	localparam int PHASE_ITEMS     = 250;

	// Sink pacing modes.
	localparam int SINK_ALWAYS  = 0;
	localparam int SINK_PATTERN = 1;

	// Byte content styles inside a chunk.
	localparam int STYLE_RANDOM   = 0;
	localparam int STYLE_LOUD_UP  = 1;
	localparam int STYLE_LOUD_DN  = 2;
	localparam int STYLE_QUIET    = 3;
	localparam int STYLE_LOUD_MIX = 4;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	sadpcm_byte_if coded_ch ();
	sadpcm_pcm_if  pcm_ch ();

	stereo_adpcm_nibble_decoder_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.coded     (coded_ch),
		.decoded   (pcm_ch)
	);

	stereo_sample_tracker tracker;

	// Shared pacing controls, set by the stimulus process.
	int   sink_mode;
	bit   hold_off_req;
	bit   src_gaps;
	int   burst_left;
	int   settings_used;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ---------------------------------------------------------------------
	// Sender side
	// ---------------------------------------------------------------------

	// Present one byte and hold it until the block takes it. On return the
	// current time step is the accepting edge, so the caller may drive the
	// next beat (or drop valid) with a single assignment.
	task send_code_byte(input logic [BYTE_W-1:0] code_byte, input logic first_of_chunk);
		coded_ch.valid          <= 1'b1;
		coded_ch.code_byte      <= code_byte;
		coded_ch.first_of_chunk <= first_of_chunk;
		@(posedge clk);
		while (!coded_ch.ready) @(posedge clk);
		tracker.decode_byte(code_byte, first_of_chunk);
	endtask

	// Bursts of random length; between most bursts drop valid for a few cycles
	// unless gaps are switched off for this stretch.
	task paced_send(input logic [BYTE_W-1:0] code_byte, input logic first_of_chunk);
		if (burst_left == 0) begin
			if (src_gaps && $urandom_range(0, 3) != 0) begin
				coded_ch.valid <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		send_code_byte(code_byte, first_of_chunk);
	endtask

	// Drop valid, let every pending pair drain, then write all four init
	// registers back to back. Index data may carry junk above bit 6.
	task program_init(input logic [CFG_DATA_W-1:0] left_sample,
			input logic [CFG_DATA_W-1:0] left_index,
			input logic [CFG_DATA_W-1:0] right_sample,
			input logic [CFG_DATA_W-1:0] right_index);
		coded_ch.valid <= 1'b0;
		while (tracker.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= REG_INIT_LEFT_SAMPLE;
		cfg_data  <= left_sample;
		@(posedge clk);
		tracker.write_reg(REG_INIT_LEFT_SAMPLE, left_sample);
		cfg_index <= REG_INIT_LEFT_INDEX;
		cfg_data  <= left_index;
		@(posedge clk);
		tracker.write_reg(REG_INIT_LEFT_INDEX, left_index);
		cfg_index <= REG_INIT_RIGHT_SAMPLE;
		cfg_data  <= right_sample;
		@(posedge clk);
		tracker.write_reg(REG_INIT_RIGHT_SAMPLE, right_sample);
		cfg_index <= REG_INIT_RIGHT_INDEX;
		cfg_data  <= right_index;
		@(posedge clk);
		tracker.write_reg(REG_INIT_RIGHT_INDEX, right_index);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	// Index data: mostly legal 0..88, a quarter above 88 to hit the load clamp.
	function automatic logic [CFG_DATA_W-1:0] random_index_data();
		logic [CFG_DATA_W-1:0] d;
		d = CFG_DATA_W'($urandom);
		if ($urandom_range(0, 3) == 0)
			d[INDEX_W-1:0] = INDEX_W'($urandom_range(89, 127));
		else
			d[INDEX_W-1:0] = INDEX_W'($urandom_range(0, IDX_LAST));
		return d;
	endfunction

	// One nibble in the given style: loud codes push the index up and drive
	// the predictor into saturation, quiet codes walk the index down to 0.
	function automatic logic [CODE_W-1:0] pick_nibble(int style);
		logic [CODE_W-1:0] n;
		n = CODE_W'($urandom);
		case (style)
			STYLE_LOUD_UP: begin
				n[MAG_W-1:0] = MAG_W'($urandom_range(4, 7));
				n[MAG_W]     = 1'b0;
			end
			STYLE_LOUD_DN: begin
				n[MAG_W-1:0] = MAG_W'($urandom_range(4, 7));
				n[MAG_W]     = 1'b1;
			end
			STYLE_QUIET:    n[MAG_W-1:0] = MAG_W'($urandom_range(0, 3));
			STYLE_LOUD_MIX: n[MAG_W-1:0] = MAG_W'($urandom_range(4, 7));
			default: ;
		endcase
		return n;
	endfunction

	// Random chunks: most start with the chunk flag and carry styled content;
	// a few start without it, and a stray flag now and then breaks a chunk.
	task random_phase(input int n_items, input int hold_at);
		int sent;
		int chunk_len;
		int style;
		int k;
		logic [BYTE_W-1:0] b;
		logic first;
		sent = 0;
		while (sent < n_items) begin
			chunk_len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
			                                        : $urandom_range(1, 48);
			style = ($urandom_range(0, 2) == 0) ? STYLE_RANDOM
			                                    : $urandom_range(STYLE_RANDOM, STYLE_LOUD_MIX);
			for (k = 0; k < chunk_len && sent < n_items; k++) begin
				b = {pick_nibble(style), pick_nibble(style)};
				first = (k == 0) ? ($urandom_range(0, 15) != 0) : ($urandom_range(0, 63) == 0);
				paced_send(b, first);
				sent++;
				// Start the long sink hold-off while bytes keep coming.
				if (sent == hold_at) hold_off_req = 1'b1;
			end
		end
	endtask

	// ---------------------------------------------------------------------
	// Receiver side: always ready, or alternating ready and stall runs, with
	// one long hold-off on request. Each branch advances at least one edge,
	// so ready never gets two assignments in one step.
	// ---------------------------------------------------------------------
	initial begin : sink_pacing
		int hi_run;
		int lo_run;
		pcm_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_off_req) begin
				pcm_ch.ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				hold_off_req = 1'b0;
			end else if (sink_mode == SINK_ALWAYS) begin
				pcm_ch.ready <= 1'b1;
				@(posedge clk);
			end else begin
				hi_run = $urandom_range(1, 12);
				lo_run = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				pcm_ch.ready <= 1'b1;
				repeat (hi_run) @(posedge clk);
				if (lo_run != 0) begin
					pcm_ch.ready <= 1'b0;
					repeat (lo_run) @(posedge clk);
				end
			end
		end
	end

	// Check every sample pair beat against the oldest prediction. Values are
	// those from before the edge, so the check is race free.
	always @(posedge clk) begin
		if (arst_n && pcm_ch.valid && pcm_ch.ready)
			tracker.compare_pair(pcm_ch.left_sample, pcm_ch.right_sample);
	end

	// End the run when no beat moves on either channel for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((coded_ch.valid && coded_ch.ready) || (pcm_ch.valid && pcm_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("TIMEOUT: no beat on either channel for %0d cycles", WATCHDOG_LIMIT);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// ---------------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------------
	initial begin : stimulus
		int i;
		int p;
		tracker = new();
		sink_mode     = SINK_ALWAYS;
		hold_off_req  = 1'b0;
		src_gaps      = 1'b1;
		burst_left    = 0;
		settings_used = 0;

		// Hold every input at a known value through reset.
		arst_n                  <= 1'b0;
		cfg_we                  <= 1'b0;
		cfg_index               <= REG_INIT_LEFT_SAMPLE;
		cfg_data                <= '0;
		coded_ch.valid          <= 1'b0;
		coded_ch.code_byte      <= '0;
		coded_ch.first_of_chunk <= 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Decode straight from the reset state, no chunk flag yet.
		paced_send(8'h77, 1'b0);
		paced_send(8'hF0, 1'b0);
		paced_send(8'h08, 1'b0);

		// Extremes: left at +max, right at -max, both indices at the top; the
		// right index register holds 127 and must load as 88.
		program_init(16'h7FFF, 16'hFF58, 16'h8000, 16'h007F);
		paced_send(8'h7F, 1'b1);
		paced_send(8'h77, 1'b0);
		paced_send(8'hF7, 1'b0);
		paced_send(8'h80, 1'b0);

		// Left index 89 clamps on load; right starts at -1 with index 0.
		program_init(16'h0000, 16'h0059, 16'hFFFF, 16'h0000);
		paced_send(8'h00, 1'b1);

		// Every code on each nibble, opposite codes side by side.
		for (i = 0; i < 16; i++)
			paced_send({i[3:0], ~i[3:0]}, 1'b0);

		// Random phases. Drain and reprogram before each one; the first two
		// use the register extremes, the rest random settings.
		for (p = 0; p < PHASES; p++) begin
			case (p)
				0: program_init(16'h7FFF, 16'hFFFF, 16'h7FFF, 16'hFFFF);
				1: program_init(16'h8000, 16'h0000, 16'h8000, 16'h0000);
				default: program_init(16'($urandom), random_index_data(),
					16'($urandom), random_index_data());
			endcase
			// Phase 0 runs with no idling on either side.
			sink_mode = (p == 0) ? SINK_ALWAYS : ((p % 3 == 2) ? SINK_ALWAYS : SINK_PATTERN);
			src_gaps  = (p != 0) && (p != 4);
			random_phase(PHASE_ITEMS, (p == 3) ? 60 : -1);
		end

		// Let the last pairs come out, then settle.
		coded_ch.valid <= 1'b0;
		while (tracker.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Decoded %0d code bytes with %0d chunk reloads into %0d checked pairs",
			tracker.bytes_decoded, tracker.chunk_reloads, tracker.pairs_checked);
		$display("Register settings: %0d, predicted saturations: %0d, mismatches: %0d",
			settings_used, tracker.saturations, tracker.mismatches);
		if (tracker.mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
